// ===== src/bcaa_pkg.sv =====
// Package for the battery-compensated angle block: widths, constants, state and command types.
// Used by the channel interfaces, the controller, the datapath, the divider and the top level.
`default_nettype none

package bcaa_pkg;

    localparam int CODE_W     = 24;
    localparam int BATT_W     = 10;
    localparam int MODE_W     = 2;
    localparam int ANGLE_W    = 16;
    localparam int OFS_W      = 18;
    localparam int MEAN_W     = 25;
    localparam int M_W        = 32;
    localparam int T_W        = 36;
    localparam int T25_W      = 41;
    localparam int DEN_W      = 25;
    localparam int DVD_W      = 50;
    localparam int DVS_W      = 24;
    localparam int RAW_W      = 40;
    localparam int NUM_SHIFT  = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE       = 1'd1;

    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;
    localparam logic [MODE_W-1:0] MODE_18BIT = 2'd3;
    localparam logic [BATT_W-1:0] KNEE_RESET = 10'd796;

    localparam logic signed [DEN_W-1:0] DEN_NOMINAL = 25'sd9420800;
    localparam logic signed [DEN_W-1:0] DEN_BIAS    = 25'sd737280;
    localparam logic [13:0]             DEN_SLOPE   = 14'd12639;
    localparam logic signed [T_W-1:0]   V_BIAS      = 36'sd46080;

    localparam logic [ANGLE_W-1:0]     ANGLE_MAX = 16'hFFFF;
    localparam logic signed [OFS_W-1:0] OFS_MAX  = 18'sd131071;
    localparam logic signed [OFS_W-1:0] OFS_MIN  = -18'sd131072;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_ROUND,
        ST_MEAN,
        ST_SCALE,
        ST_NUMER,
        ST_RAW_START,
        ST_RAW_WAIT,
        ST_FINISH,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic round;
        logic mean;
        logic scale;
        logic numer;
        logic raw_start;
        logic finish;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic window_last;
        logic div_done;
        logic den_fault;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/bcaa_in_if.sv =====
// Input channel: one converter reading word with valid/ready handshake.
// Depends on bcaa_pkg for field widths.
`default_nettype none

interface bcaa_in_if import bcaa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [7:0]        code_byte0;
    logic [7:0]        code_byte1;
    logic [7:0]        code_byte2;
    logic [BATT_W-1:0] battery_count;
    logic              zero_request;

    modport source (output valid, code_byte0, code_byte1, code_byte2, battery_count,
                    zero_request, input ready);
    modport sink   (input valid, code_byte0, code_byte1, code_byte2, battery_count,
                    zero_request, output ready);
endinterface

`default_nettype wire

// ===== src/bcaa_out_if.sv =====
// Output channel: one angle result word with valid/ready handshake.
// Depends on bcaa_pkg for field widths.
`default_nettype none

interface bcaa_out_if import bcaa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle_q8;
    logic               denominator_fault;
    logic               offset_taken;

    modport source (output valid, angle_q8, denominator_fault, offset_taken, input ready);
    modport sink   (input valid, angle_q8, denominator_fault, offset_taken, output ready);
endinterface

`default_nettype wire

// ===== src/bcaa_cfg_if.sv =====
// Configuration write channel: register index and write data with valid/ready handshake.
// Depends on bcaa_pkg for field widths.
`default_nettype none

interface bcaa_cfg_if import bcaa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/bcaa_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle, used for the angle quotient.
// Depends on bcaa_pkg for the dividend and divisor widths.
`default_nettype none

module bcaa_divider import bcaa_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W+1:0] diff;
    logic             qbit;
    logic [DVS_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        qbit     = ~diff[DVS_W+1];
        rem_next = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/bcaa_datapath.sv =====
// Datapath: configuration registers, window accumulator, span and numerator arithmetic,
// zero offset and the output word register. Depends on bcaa_pkg and bcaa_divider.
`default_nettype none

module bcaa_datapath import bcaa_pkg::*; #(
    parameter int WINDOW = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [7:0]            code_byte0,
    input  wire logic [7:0]            code_byte1,
    input  wire logic [7:0]            code_byte2,
    input  wire logic [BATT_W-1:0]     battery_count,
    input  wire logic                  zero_request,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [ANGLE_W-1:0]    angle_q8,
    output logic                       denominator_fault,
    output logic                       offset_taken
);

    localparam int SUM_W  = CODE_W + $clog2(WINDOW) + 1;
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int RCP_SH = MAG_W + $clog2(WINDOW);
    localparam int RCP_W  = MAG_W + 1;

    // The rounded sum is divided by WINDOW as a multiplication by a rounded-up reciprocal.
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [MODE_W-1:0] mode_reg;
    logic [BATT_W-1:0] knee_reg;

    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [BATT_W-1:0]       held_reg;
    logic                    zreq_reg;
    logic                    window_last;

    logic signed [OFS_W-1:0] offset_reg;

    logic                    mean_neg_reg;
    logic [MAG_W-1:0]        rnd_mag_reg;
    logic [MEAN_W-1:0]       mean_mag_reg;
    logic signed [T_W-1:0]   t_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic                    num_neg_reg;
    logic [DVD_W-1:0]        num_mag_reg;
    logic signed [RAW_W-1:0] raw_reg;

    logic               out_valid_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic               fault_reg;
    logic               taken_reg;

    logic signed [CODE_W-1:0] code_ext;
    logic signed [SUM_W-1:0]  sum_base;
    logic signed [SUM_W-1:0]  rnd;
    logic [SUM_W-1:0]         rnd_mag;
    logic [MAG_W+RCP_W-1:0]   mean_prod;

    logic                     div_start;
    logic [DVD_W-1:0]         div_dividend;
    logic [DVS_W-1:0]         div_divisor;
    logic                     div_busy;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quotient;

    logic signed [MEAN_W-1:0] mean_s;
    logic [2:0]               shift;
    logic signed [M_W-1:0]    m_val;
    logic signed [T_W-1:0]    t_next;
    logic [23:0]              den_prod;
    logic signed [DEN_W-1:0]  den_next;
    logic                     den_fault;

    logic signed [T25_W-1:0]  t25;
    logic [T25_W-1:0]         t25_mag;
    logic [RAW_W-2:0]         raw_mag;
    logic signed [RAW_W-1:0]  raw_next;

    logic signed [RAW_W:0]    ang;
    logic [ANGLE_W-1:0]       ang_clamped;
    logic signed [RAW_W:0]    neg_raw;
    logic signed [OFS_W-1:0]  offset_next;
    logic                     out_free;

    bcaa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        if (mode_reg == MODE_18BIT)
            code_ext = {code_byte0, code_byte1, code_byte2};
        else
            code_ext = {{8{code_byte0[7]}}, code_byte0, code_byte1};
        sum_base    = (pos_reg == '0) ? '0 : sum_reg;
        sum_next    = sum_base + SUM_W'(code_ext);
        window_last = (pos_reg == POS_W'(WINDOW - 1));
        pos_next    = window_last ? '0 : pos_reg + 1'b1;
    end

    always_comb
    begin
        rnd       = sum_reg + SUM_W'(WINDOW / 2);
        rnd_mag   = rnd[SUM_W-1] ? SUM_W'(-rnd) : SUM_W'(rnd);
        mean_prod = rnd_mag_reg * RECIP;

        div_start    = cmd.raw_start;
        div_dividend = num_mag_reg;
        div_divisor  = den_reg[DVS_W-1:0];
    end

    always_comb
    begin
        mean_s   = mean_neg_reg ? -$signed(mean_mag_reg) : $signed(mean_mag_reg);
        shift    = {2'd3 - mode_reg, 1'b0};
        m_val    = M_W'(mean_s) <<< shift;
        t_next   = (T_W'(m_val) <<< 3) + T_W'(m_val) - V_BIAS;
        den_prod = 24'(held_reg) * DEN_SLOPE;
        if (held_reg >= knee_reg)
            den_next = DEN_NOMINAL;
        else
            den_next = $signed({1'b0, den_prod}) - DEN_BIAS;
        den_fault = den_reg[DEN_W-1] || (den_reg == '0);
    end

    always_comb
    begin
        t25      = (T25_W'(t_reg) <<< 4) + (T25_W'(t_reg) <<< 3) + T25_W'(t_reg);
        t25_mag  = t25[T25_W-1] ? T25_W'(-t25) : T25_W'(t25);
        raw_mag  = div_quotient[RAW_W-2:0];
        raw_next = num_neg_reg ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});
    end

    always_comb
    begin
        ang = (RAW_W + 1)'(raw_reg) + (RAW_W + 1)'(offset_reg);
        if (ang[RAW_W])
            ang_clamped = '0;
        else if (|ang[RAW_W-1:ANGLE_W])
            ang_clamped = ANGLE_MAX;
        else
            ang_clamped = ang[ANGLE_W-1:0];

        neg_raw = -((RAW_W + 1)'(raw_reg));
        if ((neg_raw[RAW_W:OFS_W-1] == '0) || (neg_raw[RAW_W:OFS_W-1] == '1))
            offset_next = neg_raw[OFS_W-1:0];
        else if (neg_raw[RAW_W])
            offset_next = OFS_MIN;
        else
            offset_next = OFS_MAX;

        out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            knee_reg      <= KNEE_RESET;
            pos_reg       <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RESOLUTION: mode_reg <= cfg_data[MODE_W-1:0];
                    REG_KNEE:       knee_reg <= cfg_data[BATT_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.accept)
                pos_reg <= pos_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (!den_fault && zreq_reg)
                    offset_reg <= offset_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sum_reg  <= sum_next;
            zreq_reg <= zero_request;
            if (pos_reg == '0)
                held_reg <= battery_count;
        end
        if (cmd.round)
        begin
            mean_neg_reg <= rnd[SUM_W-1];
            rnd_mag_reg  <= rnd_mag[MAG_W-1:0];
        end
        if (cmd.mean)
            mean_mag_reg <= MEAN_W'(mean_prod >> RCP_SH);
        if (cmd.scale)
        begin
            t_reg   <= t_next;
            den_reg <= den_next;
        end
        if (cmd.numer)
        begin
            num_neg_reg <= t25[T25_W-1];
            num_mag_reg <= {t25_mag[DVD_W-NUM_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
        end
        if (cmd.finish)
            raw_reg <= raw_next;
        if (cmd.emit)
        begin
            if (den_fault)
            begin
                angle_reg <= '0;
                fault_reg <= 1'b1;
                taken_reg <= 1'b0;
            end
            else
            begin
                angle_reg <= ang_clamped;
                fault_reg <= 1'b0;
                taken_reg <= zreq_reg;
            end
        end
    end

    assign status.window_last = window_last;
    assign status.div_done    = div_done;
    assign status.den_fault   = den_fault;
    assign status.out_free    = out_free;

    assign out_valid         = out_valid_reg;
    assign angle_q8          = angle_reg;
    assign denominator_fault = fault_reg;
    assign offset_taken      = taken_reg;

`ifndef ASSERT_OFF
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !div_busy)
        else $error("input word accepted during computation");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result written over a pending output word");

    a_offset_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.emit |=> $stable(offset_reg))
        else $error("zero offset changed without a result");

    a_taken_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(taken_reg && fault_reg))
        else $error("offset taken on a faulted result");
`endif

endmodule

`default_nettype wire

// ===== src/bcaa_ctrl.sv =====
// Controller state machine: sequences accumulation, the mean, the angle division and the result.
// Depends on bcaa_pkg for the state, command and status types.
`default_nettype none

module bcaa_ctrl import bcaa_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCUM;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
                if (in_valid && status.window_last)
                    state_next = ST_ROUND;
            ST_ROUND:
                state_next = ST_MEAN;
            ST_MEAN:
                state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_NUMER;
            ST_NUMER:
                state_next = status.den_fault ? ST_EMIT : ST_RAW_START;
            ST_RAW_START:
                state_next = ST_RAW_WAIT;
            ST_RAW_WAIT:
                if (status.div_done)
                    state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_EMIT;
            ST_EMIT:
                if (status.out_free)
                    state_next = ST_ACCUM;
            default:
                state_next = ST_ACCUM;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_ACCUM);
        cmd.accept    = in_ready && in_valid;
        cmd.round     = (state_reg == ST_ROUND);
        cmd.mean      = (state_reg == ST_MEAN);
        cmd.scale     = (state_reg == ST_SCALE);
        cmd.numer     = (state_reg == ST_NUMER);
        cmd.raw_start = (state_reg == ST_RAW_START);
        cmd.finish    = (state_reg == ST_FINISH);
        cmd.emit      = (state_reg == ST_EMIT) && status.out_free;
    end

endmodule

`default_nettype wire

// ===== src/battery_compensated_angle_from_adc.sv =====
// Battery-compensated angle from converter readings, top level.
// The result word of a window follows the accept of its last word and is set mostly by the 50-step
// serial angle divider; when the sensor span is not positive the division is skipped.
// Words are taken one per cycle in a window; no word is taken while a window's result is computed.
// Reset (rst_n, asynchronous, active low) clears the window, the zero offset and the output,
// and loads the resolution mode and battery knee defaults.
`default_nettype none

module battery_compensated_angle_from_adc import bcaa_pkg::*; #(
    parameter int WINDOW = 4
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bcaa_in_if.sink   in_ch,
    bcaa_cfg_if.sink  cfg_ch,
    bcaa_out_if.source out_ch
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_write;

    assign cfg_ch.ready = 1'b1;
    assign cfg_write    = cfg_ch.valid;

    bcaa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bcaa_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_ch.index),
        .cfg_data          (cfg_ch.data),
        .code_byte0        (in_ch.code_byte0),
        .code_byte1        (in_ch.code_byte1),
        .code_byte2        (in_ch.code_byte2),
        .battery_count     (in_ch.battery_count),
        .zero_request      (in_ch.zero_request),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .angle_q8          (out_ch.angle_q8),
        .denominator_fault (out_ch.denominator_fault),
        .offset_taken      (out_ch.offset_taken)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for battery_compensated_angle_from_adc: predicts each window's angle word and
// compares it with the block's output while the input and output channels idle at random.
// Depends on bcaa_pkg and the bcaa_in_if, bcaa_out_if and bcaa_cfg_if interfaces.
`timescale 1ns / 1ps

module tb_top;
    import bcaa_pkg::*;

    localparam int WINDOW      = 4;
    localparam int SETTLE      = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TARGET      = 1200;

    localparam logic [MODE_W-1:0] MODE_12BIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_14BIT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_16BIT = 2'd2;

    typedef struct packed {
        logic [7:0]        b0;
        logic [7:0]        b1;
        logic [7:0]        b2;
        logic [BATT_W-1:0] batt;
        logic              zreq;
    } reading_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               fault;
        logic               taken;
    } angle_word_t;

    class angle_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [BATT_W-1:0] knee;
        int unsigned       fill;
        longint            code_sum;
        logic [BATT_W-1:0] held_batt;
        longint            offset_q8;
        angle_word_t       expected_q[$];
        int unsigned       readings;
        int unsigned       words_checked;
        int unsigned       faults_seen;
        int unsigned       zero_captures;
        int unsigned       settings;
        int unsigned       mismatches;

        function new();
            mode          = MODE_16BIT;
            knee          = 10'd796;
            fill          = 0;
            code_sum      = 0;
            held_batt     = '0;
            offset_q8     = 0;
            readings      = 0;
            words_checked = 0;
            faults_seen   = 0;
            zero_captures = 0;
            settings      = 0;
            mismatches    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            settings++;
            if (idx == REG_RESOLUTION)
                mode = data[MODE_W-1:0];
            else if (idx == REG_KNEE)
                knee = data[BATT_W-1:0];
        endfunction

        function longint extend_code(reading_t r);
            logic signed [23:0] c24;
            logic signed [15:0] c16;
            if (mode == MODE_18BIT)
            begin
                c24 = {r.b0, r.b1, r.b2};
                return longint'(c24);
            end
            c16 = {r.b0, r.b1};
            return longint'(c16);
        endfunction

        function void note_reading(reading_t r);
            longint      mean;
            longint      m;
            longint      den;
            longint      raw;
            longint      ang;
            longint      neg;
            int          shift;
            angle_word_t w;
            readings++;
            if (fill == 0)
            begin
                held_batt = r.batt;
                code_sum  = 0;
            end
            code_sum += extend_code(r);
            fill++;
            if (fill < WINDOW)
                return;
            fill  = 0;
            mean  = (code_sum + longint'(WINDOW / 2)) / longint'(WINDOW);
            shift = 2 * (3 - int'(mode));
            m     = mean * (longint'(1) << shift);
            if (held_batt >= knee)
                den = 9420800;
            else
                den = 12639 * longint'(held_batt) - 737280;
            if (den <= 0)
            begin
                w.angle = '0;
                w.fault = 1'b1;
                w.taken = 1'b0;
            end
            else
            begin
                raw = (204800 * (9 * m - 46080)) / den;
                ang = raw + offset_q8;
                if (ang < 0)
                    ang = 0;
                if (ang > 65535)
                    ang = 65535;
                w.angle = ang[ANGLE_W-1:0];
                w.fault = 1'b0;
                w.taken = r.zreq;
                if (r.zreq)
                begin
                    neg = -raw;
                    if (neg > 131071)
                        neg = 131071;
                    if (neg < -131072)
                        neg = -131072;
                    offset_q8 = neg;
                end
            end
            expected_q.push_back(w);
        endfunction

        function void check_result(angle_word_t got);
            angle_word_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word: angle=%0d fault=%0b offset_taken=%0b",
                         $time, got.angle, got.fault, got.taken);
                return;
            end
            want = expected_q.pop_front();
            words_checked++;
            if (got.fault === 1'b1)
                faults_seen++;
            if (got.taken === 1'b1)
                zero_captures++;
            if (got.angle !== want.angle)
            begin
                mismatches++;
                $display("%0t: angle_q8 expected %0d, got %0d", $time, want.angle, got.angle);
            end
            if (got.fault !== want.fault)
            begin
                mismatches++;
                $display("%0t: denominator_fault expected %0b, got %0b",
                         $time, want.fault, got.fault);
            end
            if (got.taken !== want.taken)
            begin
                mismatches++;
                $display("%0t: offset_taken expected %0b, got %0b", $time, want.taken, got.taken);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   stall_left;
    bit   gaps_on;
    bit   stalls_on;

    angle_scoreboard sb = new();

    bcaa_in_if  in_ch ();
    bcaa_out_if out_ch ();
    bcaa_cfg_if cfg_ch ();

    battery_compensated_angle_from_adc #(.WINDOW(WINDOW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 4) == 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.angle_q8, out_ch.denominator_fault, out_ch.offset_taken});
    end

    function automatic reading_t build_reading(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                               logic [BATT_W-1:0] batt, logic zreq);
        reading_t r;
        r.b0   = b0;
        r.b1   = b1;
        r.b2   = b2;
        r.batt = batt;
        r.zreq = zreq;
        return r;
    endfunction

    function automatic reading_t make_reading(logic [MODE_W-1:0] mode, logic [BATT_W-1:0] knee);
        reading_t   r;
        logic [7:0] edges [4];
        int         kind;
        int         mval;
        int         batt;
        logic [23:0] code;
        edges = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        kind  = $urandom_range(0, 9);
        r.b0  = 8'($urandom);
        r.b1  = 8'($urandom);
        r.b2  = 8'($urandom);
        if (kind == 0)
        begin
            r.b0 = edges[$urandom_range(0, 3)];
            r.b1 = edges[$urandom_range(0, 3)];
            r.b2 = edges[$urandom_range(0, 3)];
        end
        else if (kind > 2)
        begin
            mval = int'($urandom_range(0, 140000)) - 3000;
            code = 24'(mval >>> (2 * (3 - int'(mode))));
            if (mode == MODE_18BIT)
                {r.b0, r.b1, r.b2} = code;
            else
                {r.b0, r.b1} = code[15:0];
        end
        kind = $urandom_range(0, 19);
        if (kind < 13)
        begin
            batt = int'(knee) + int'($urandom_range(0, 80)) - 40;
            if (batt < 0)
                batt = 0;
            if (batt > 1023)
                batt = 1023;
            r.batt = BATT_W'(batt);
        end
        else if (kind < 16)
            r.batt = BATT_W'($urandom);
        else
        begin
            case ($urandom_range(0, 3))
                0: r.batt = 10'd0;
                1: r.batt = 10'd58;
                2: r.batt = 10'd59;
                default: r.batt = 10'd1023;
            endcase
        end
        r.zreq = ($urandom_range(0, 9) == 0);
        return r;
    endfunction

    task automatic push_reading(reading_t r);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.code_byte0    <= r.b0;
        in_ch.code_byte1    <= r.b1;
        in_ch.code_byte2    <= r.b2;
        in_ch.battery_count <= r.batt;
        in_ch.zero_request  <= r.zreq;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_reading(r);
        @(negedge clk);
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int               phase;
        int               n;
        logic [BATT_W-1:0] knee;

        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.code_byte0    = '0;
        in_ch.code_byte1    = '0;
        in_ch.code_byte2    = '0;
        in_ch.battery_count = '0;
        in_ch.zero_request  = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        stall_left          = 0;
        gaps_on             = 1'b1;
        stalls_on           = 1'b1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings first, then saturation, clamping, offset limits and span faults.
        push_reading(build_reading(8'h12, 8'h34, 8'hA5, 10'd800, 1'b1));
        push_reading(build_reading(8'h12, 8'h30, 8'h5A, 10'd0, 1'b0));
        push_reading(build_reading(8'h12, 8'h38, 8'hFF, 10'd1023, 1'b1));
        push_reading(build_reading(8'h12, 8'h34, 8'h00, 10'd5, 1'b0));
        end_burst();
        wait_quiet();
        write_cfg(REG_RESOLUTION, {8'hFF, MODE_12BIT});
        write_cfg(REG_KNEE, 10'd796);
        repeat (3) push_reading(build_reading(8'h7F, 8'hFF, 8'hFF, 10'd1023, 1'b0));
        push_reading(build_reading(8'h7F, 8'hFF, 8'hFF, 10'd1023, 1'b1));
        repeat (4) push_reading(build_reading(8'h80, 8'h00, 8'h00, 10'd1023, 1'b0));
        repeat (3) push_reading(build_reading(8'h00, 8'h00, 8'h00, 10'd59, 1'b0));
        push_reading(build_reading(8'h00, 8'h00, 8'h00, 10'd59, 1'b1));
        repeat (3) push_reading(build_reading(8'h40, 8'h00, 8'h00, 10'd58, 1'b0));
        push_reading(build_reading(8'h40, 8'h00, 8'h00, 10'd58, 1'b1));
        end_burst();
        wait_quiet();

        // The resolution changes halfway through this window.
        write_cfg(REG_RESOLUTION, {8'h00, MODE_18BIT});
        write_cfg(REG_KNEE, 10'd0);
        push_reading(build_reading(8'hFF, 8'hFF, 8'hFF, 10'd0, 1'b0));
        push_reading(build_reading(8'h00, 8'h00, 8'h01, 10'd0, 1'b1));
        end_burst();
        wait_quiet();
        write_cfg(REG_RESOLUTION, {8'h55, MODE_14BIT});
        push_reading(build_reading(8'h01, 8'h00, 8'hC3, 10'd512, 1'b0));
        push_reading(build_reading(8'hFF, 8'hFF, 8'h00, 10'd1023, 1'b1));
        end_burst();

        phase = 0;
        while (sb.readings < TARGET)
        begin
            wait_quiet();
            if (sb.readings > 1050)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            case (phase % 6)
                0: knee = 10'd0;
                1: knee = 10'd1023;
                2: knee = 10'd796;
                3: knee = 10'd59;
                default: knee = BATT_W'($urandom);
            endcase
            write_cfg(REG_RESOLUTION, {8'($urandom), 2'(phase % 4)});
            write_cfg(REG_KNEE, knee);
            n = $urandom_range(30, 110);
            repeat (n) push_reading(make_reading(sb.mode, sb.knee));
            end_burst();
            phase++;
        end

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d readings under %0d register writes; checked %0d angle words.",
                 sb.readings, sb.settings, sb.words_checked);
        $display("Words with a span fault: %0d, with a zero capture: %0d, mismatches: %0d.",
                 sb.faults_seen, sb.zero_captures, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
